/* src/bfbp_pkg.sv */
// ----------------------------------------------------------------------------
// bfbp_pkg
// shared types, codes and defaults of the best-fit buffer pool
// ----------------------------------------------------------------------------
package bfbp_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int SIZE_BITS_DEF = 24;

	localparam int FUNC_W   = 2;
	localparam int REQ_W    = 24;
	localparam int HANDLE_W = 4;
	localparam int SLOT_O_W = 4;
	localparam int STAMP_W  = 16;
	localparam int MAXB_W   = 5;

	localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ABORT   = 2'd2;

	localparam logic [MAXB_W-1:0] MAXB_RESET = 5'd16;

	// apb register map
	localparam int          PADDR_W          = 2;
	localparam logic [1:0]  ADDR_MAX_BUFFERS = 2'd0;

	typedef enum logic [2:0] {
		ST_REUSED   = 3'd0,
		ST_NEW      = 3'd1,
		ST_EVICT    = 3'd2,
		ST_WAIT     = 3'd3,
		ST_ABORTED  = 3'd4,
		ST_RELEASED = 3'd5,
		ST_IGNORED  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CMD_REQUEST,
		CMD_RELEASE,
		CMD_ABORT,
		CMD_IGNORE
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DRAIN,
		BK_COMMIT
	} back_state_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [REQ_W-1:0]    size;
		logic [HANDLE_W-1:0] handle;
	} item_t;

	typedef struct packed {
		status_t             status;
		logic [SLOT_O_W-1:0] slot;
		logic [REQ_W-1:0]    slot_size;
		logic [SLOT_O_W-1:0] evicted_slot;
	} result_t;

endpackage

/* src/bfbp_if.sv */
// ----------------------------------------------------------------------------
// bfbp channel interfaces
// valid/ready channels for commands into and results out of the pool
// ----------------------------------------------------------------------------
interface bfbp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [23:0] request_size;
	logic [3:0]  release_handle;
	logic        handle_is_null;

	modport source (output valid, func, request_size, release_handle, handle_is_null,
		input ready);
	modport sink (input valid, func, request_size, release_handle, handle_is_null,
		output ready);
endinterface

interface bfbp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  slot;
	logic [23:0] slot_size;
	logic [3:0]  evicted_slot;

	modport source (output valid, status, slot, slot_size, evicted_slot, input ready);
	modport sink (input valid, status, slot, slot_size, evicted_slot, output ready);
endinterface

/* src/best_fit_buffer_pool_unit.sv */
// ----------------------------------------------------------------------------
// best_fit_buffer_pool_unit
// best-fit buffer slot allocator with eviction, release and abort
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one command per beat: request a buffer of at least
//   request_size bytes, release a slot handle, or abort the pool.
//   out_ch returns exactly one result beat per command, in order.
//   the apb port holds max_buffers at address 0; write it only while idle.
// scan and command flow
//   a request scans every slot through the size and stamp stores, one slot
//   per cycle; release, abort and ignored commands, and requests once the
//   pool is aborted, skip the scan. the engine works on one command at a
//   time and takes the next from the queue only once it has committed the
//   result of the last, so the slot scan sets the rate.
// reset
//   arst_n clears the pool: nothing tracked, nothing free, stamps at zero,
//   not aborted, max_buffers back to 16. size and stamp stores are not
//   cleared; they are only read for slots that were written.
// back pressure
//   a two-entry queue sits between decode and the engine, so commands are
//   taken while a result waits; when out_ch stalls the engine holds its
//   result and the queue fills, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module best_fit_buffer_pool_unit
	import bfbp_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	bfbp_in_if.sink            in_ch,
	bfbp_out_if.source         out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CNT_W = $clog2(SLOTS + 1);

	logic [MAXB_W-1:0] max_buffers_q;
	logic [CNT_W-1:0]  limit;
	logic              q_valid;
	item_t             q_item;
	logic              q_pop;
	result_t           res;

	// register port: single register, pready always high
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MAX_BUFFERS) ? 32'(max_buffers_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_buffers_q <= MAXB_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_BUFFERS) begin
			max_buffers_q <= pwdata[MAXB_W-1:0];
		end
	end

	// zero acts as one, anything above the pool size acts as the pool size
	always_comb begin
		if (max_buffers_q == '0) begin
			limit = CNT_W'(1);
		end else if (32'(max_buffers_q) > SLOTS) begin
			limit = CNT_W'(SLOTS);
		end else begin
			limit = CNT_W'(max_buffers_q);
		end
	end

	// decode and queue
	bfbp_front #(
		.SLOTS (SLOTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// pool state, scan and result register
	bfbp_back #(
		.SLOTS     (SLOTS),
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_ch.valid),
		.out_res   (res),
		.out_ready (out_ch.ready)
	);

	assign out_ch.status       = res.status;
	assign out_ch.slot         = res.slot;
	assign out_ch.slot_size    = res.slot_size;
	assign out_ch.evicted_slot = res.evicted_slot;

endmodule

/* src/bfbp_front.sv */
// ----------------------------------------------------------------------------
// bfbp_front
// command decode and two-entry queue toward the pool engine
// ----------------------------------------------------------------------------
module bfbp_front
	import bfbp_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bfbp_in_if.sink     in_ch,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	localparam logic [1:0] FULL_CNT = 2'd2;

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      item_in;
	logic       push;
	logic       handle_ok;

	// releases with null or out-of-range handles are turned into ignored commands here already
	always_comb begin
		handle_ok    = (32'(in_ch.release_handle) < SLOTS) && !in_ch.handle_is_null;
		item_in.size   = in_ch.request_size;
		item_in.handle = in_ch.release_handle;
		case (in_ch.func)
			FUNC_REQUEST: item_in.cmd = CMD_REQUEST;
			FUNC_RELEASE: item_in.cmd = handle_ok ? CMD_RELEASE : CMD_IGNORE;
			FUNC_ABORT:   item_in.cmd = CMD_ABORT;
			default:      item_in.cmd = CMD_IGNORE;
		endcase
	end

	assign in_ch.ready = (cnt_q != FULL_CNT);
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != 2'd0);
	assign q_item      = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/bfbp_back.sv */
// ----------------------------------------------------------------------------
// bfbp_back
// pool state, best-fit scan over the slots and result register
// ----------------------------------------------------------------------------
module bfbp_back
	import bfbp_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF,
	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CNT_W    = $clog2(SLOTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] limit,
	input  logic             q_valid,
	input  item_t            q_item,
	output logic             q_pop,
	output logic             out_valid,
	output result_t          out_res,
	input  logic             out_ready
);

	back_state_t state_q, state_d;

	item_t                work_q;
	logic [SLOT_W-1:0]    cnt_q;
	logic                 scan_rd;
	logic                 commit;
	logic                 start_scan;

	logic [SLOTS-1:0]     tracked_q;
	logic [SLOTS-1:0]     is_free_q;
	logic [CNT_W-1:0]     count_q;
	logic [STAMP_W-1:0]   stamp_cnt_q;
	logic                 aborted_q;

	logic [SIZE_BITS-1:0] size_mem  [SLOTS];
	logic [STAMP_W-1:0]   stamp_mem [SLOTS];

	// scan read stage
	logic                 vld_s1;
	logic [SLOT_W-1:0]    idx_s1;
	logic                 tracked_s1;
	logic                 free_s1;
	logic [SIZE_BITS-1:0] size_s1;
	logic [STAMP_W-1:0]   stamp_s1;

	// running winners
	logic                 sm_found_q, fit_found_q, blank_found_q;
	logic [SLOT_W-1:0]    sm_idx_q, fit_idx_q, blank_idx_q;
	logic [SIZE_BITS-1:0] sm_size_q, fit_size_q;
	logic [STAMP_W-1:0]   sm_age_q, fit_age_q;

	logic [SIZE_BITS-1:0] req;
	logic [SLOT_W-1:0]    hidx;
	logic [STAMP_W-1:0]   age_s1;
	logic                 cand, beats_sm, beats_fit;
	logic                 full;

	result_t              res;
	logic                 clr_free, track_new, size_we, rel, set_abort;
	logic [SLOT_W-1:0]    widx;

	assign req  = SIZE_BITS'(work_q.size);
	assign hidx = SLOT_W'(work_q.handle);
	assign full = (count_q >= limit);

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		scan_rd    = 1'b0;
		commit     = 1'b0;
		start_scan = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.cmd == CMD_REQUEST && !aborted_q) begin
						start_scan = 1'b1;
						state_d    = BK_SCAN;
					end else begin
						state_d = BK_COMMIT;
					end
				end
			end
			BK_SCAN: begin
				scan_rd = 1'b1;
				if (cnt_q == SLOT_W'(SLOTS - 1)) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				state_d = BK_COMMIT;
			end
			BK_COMMIT: begin
				if (!out_valid || out_ready) begin
					commit  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start_scan) begin
			cnt_q <= '0;
		end else if (scan_rd && cnt_q != SLOT_W'(SLOTS - 1)) begin
			cnt_q <= cnt_q + SLOT_W'(1);
		end
	end

	// size and stamp stores, one write port and one scan read port each
	always_ff @(posedge clk) begin
		if (commit && size_we) begin
			size_mem[widx] <= req;
		end
		if (scan_rd) begin
			size_s1 <= size_mem[cnt_q];
		end
	end

	always_ff @(posedge clk) begin
		if (commit && rel) begin
			stamp_mem[hidx] <= stamp_cnt_q;
		end
		if (scan_rd) begin
			stamp_s1 <= stamp_mem[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_rd) begin
			idx_s1     <= cnt_q;
			tracked_s1 <= tracked_q[cnt_q];
			free_s1    <= is_free_q[cnt_q];
		end
	end

	// compare one slot against the running winners
	always_comb begin
		age_s1    = stamp_cnt_q - stamp_s1;
		cand      = vld_s1 && tracked_s1 && free_s1;
		beats_sm  = !sm_found_q || (size_s1 < sm_size_q) ||
			(size_s1 == sm_size_q && age_s1 > sm_age_q);
		beats_fit = (size_s1 >= req) && (!fit_found_q || (size_s1 < fit_size_q) ||
			(size_s1 == fit_size_q && age_s1 > fit_age_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_found_q    <= 1'b0;
			fit_found_q   <= 1'b0;
			blank_found_q <= 1'b0;
		end else if (start_scan) begin
			sm_found_q    <= 1'b0;
			fit_found_q   <= 1'b0;
			blank_found_q <= 1'b0;
		end else begin
			if (vld_s1 && !tracked_s1) begin
				blank_found_q <= 1'b1;
			end
			if (cand && beats_sm) begin
				sm_found_q <= 1'b1;
			end
			if (cand && beats_fit) begin
				fit_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && !tracked_s1 && !blank_found_q) begin
			blank_idx_q <= idx_s1;
		end
		if (cand && beats_sm) begin
			sm_idx_q  <= idx_s1;
			sm_size_q <= size_s1;
			sm_age_q  <= age_s1;
		end
		if (cand && beats_fit) begin
			fit_idx_q  <= idx_s1;
			fit_size_q <= size_s1;
			fit_age_q  <= age_s1;
		end
	end

	// outcome of the item and the updates it makes
	always_comb begin
		res       = '{status: ST_IGNORED, slot: '0, slot_size: '0, evicted_slot: '0};
		clr_free  = 1'b0;
		track_new = 1'b0;
		size_we   = 1'b0;
		rel       = 1'b0;
		set_abort = 1'b0;
		widx      = blank_idx_q;
		case (work_q.cmd)
			CMD_REQUEST: begin
				if (aborted_q) begin
					res.status = ST_ABORTED;
				end else if (full && !sm_found_q) begin
					res.status = ST_WAIT;
				end else if (fit_found_q) begin
					res.status    = ST_REUSED;
					res.slot      = SLOT_O_W'(fit_idx_q);
					res.slot_size = REQ_W'(fit_size_q);
					clr_free      = 1'b1;
					widx          = fit_idx_q;
				end else if (full) begin
					res.status       = ST_EVICT;
					res.slot         = SLOT_O_W'(sm_idx_q);
					res.slot_size    = REQ_W'(req);
					res.evicted_slot = SLOT_O_W'(sm_idx_q);
					clr_free         = 1'b1;
					size_we          = 1'b1;
					widx             = sm_idx_q;
				end else if (!blank_found_q) begin
					res.status = ST_WAIT;
				end else begin
					res.status    = ST_NEW;
					res.slot      = SLOT_O_W'(blank_idx_q);
					res.slot_size = REQ_W'(req);
					clr_free      = 1'b1;
					track_new     = 1'b1;
					size_we       = 1'b1;
				end
			end
			CMD_RELEASE: begin
				if (tracked_q[hidx]) begin
					res.status = ST_RELEASED;
					rel        = 1'b1;
				end
			end
			CMD_ABORT: begin
				res.status = ST_ABORTED;
				set_abort  = 1'b1;
			end
			default: res.status = ST_IGNORED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q   <= '0;
			is_free_q   <= '0;
			count_q     <= '0;
			stamp_cnt_q <= '0;
			aborted_q   <= 1'b0;
		end else if (commit) begin
			if (clr_free) begin
				is_free_q[widx] <= 1'b0;
			end
			if (track_new) begin
				tracked_q[widx] <= 1'b1;
				count_q         <= count_q + CNT_W'(1);
			end
			if (rel) begin
				is_free_q[hidx] <= 1'b1;
				stamp_cnt_q     <= stamp_cnt_q + STAMP_W'(1);
			end
			if (set_abort) begin
				aborted_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_res <= res;
		end
	end

endmodule

/* sim/pool_checker.sv */
// ----------------------------------------------------------------------------
// pool_checker
// watches the command, result and apb ports of the buffer pool, predicts
// the answer to every command beat and compares each result beat with it
// ----------------------------------------------------------------------------
module pool_checker
	import bfbp_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	bfbp_in_if                 cmd_mon,
	bfbp_out_if                ans_mon,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output int                 mismatches,
	output int                 outstanding
);

	logic               slot_tracked [SLOTS];
	logic               slot_free    [SLOTS];
	logic [REQ_W-1:0]   slot_bytes   [SLOTS];
	logic [STAMP_W-1:0] slot_stamp   [SLOTS];
	logic [STAMP_W-1:0] next_stamp;
	logic [MAXB_W-1:0]  live_count;
	logic [MAXB_W-1:0]  max_buffers_reg;
	logic               pool_aborted;
	result_t            awaited_answers [$];
	result_t            want;

	// wrapping distance since the slot was freed
	function automatic logic [STAMP_W-1:0] free_age(input int i);
		return next_stamp - slot_stamp[i];
	endfunction

	// smaller size wins, then the slot freed earlier
	function automatic bit preferred(input int a, input int b);
		if (slot_bytes[a] != slot_bytes[b])
			return slot_bytes[a] < slot_bytes[b];
		return free_age(a) > free_age(b);
	endfunction

	function automatic result_t serve_command(input logic [FUNC_W-1:0] func,
			input logic [REQ_W-1:0] size, input logic [HANDLE_W-1:0] handle,
			input logic nul);
		result_t ans;
		int      limit;
		int      fit;
		int      least;
		int      blank;
		logic    full;
		ans = '0;
		ans.status = ST_IGNORED;
		limit = int'(max_buffers_reg);
		if (limit == 0)
			limit = 1;
		if (limit > SLOTS)
			limit = SLOTS;
		fit = -1;
		least = -1;
		blank = -1;
		if (func == FUNC_ABORT) begin
			pool_aborted = 1'b1;
			ans.status = ST_ABORTED;
		end else if (func == FUNC_RELEASE) begin
			if (!nul && int'(handle) < SLOTS && slot_tracked[handle]) begin
				slot_free[handle] = 1'b1;
				slot_stamp[handle] = next_stamp;
				next_stamp = next_stamp + 1'b1;
				ans.status = ST_RELEASED;
			end
		end else if (func == FUNC_REQUEST) begin
			if (pool_aborted) begin
				ans.status = ST_ABORTED;
			end else begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!slot_tracked[i]) begin
						if (blank < 0)
							blank = i;
					end else if (slot_free[i]) begin
						if (least < 0 || preferred(i, least))
							least = i;
						if (slot_bytes[i] >= size && (fit < 0 || preferred(i, fit)))
							fit = i;
					end
				end
				full = int'(live_count) >= limit;
				if (full && least < 0) begin
					ans.status = ST_WAIT;
				end else if (fit >= 0) begin
					slot_free[fit] = 1'b0;
					ans.status = ST_REUSED;
					ans.slot = SLOT_O_W'(fit);
					ans.slot_size = slot_bytes[fit];
				end else if (full) begin
					slot_free[least] = 1'b0;
					slot_bytes[least] = size;
					ans.status = ST_EVICT;
					ans.slot = SLOT_O_W'(least);
					ans.slot_size = size;
					ans.evicted_slot = SLOT_O_W'(least);
				end else if (blank < 0) begin
					ans.status = ST_WAIT;
				end else begin
					slot_tracked[blank] = 1'b1;
					slot_free[blank] = 1'b0;
					slot_bytes[blank] = size;
					live_count = live_count + 1'b1;
					ans.status = ST_NEW;
					ans.slot = SLOT_O_W'(blank);
					ans.slot_size = size;
				end
			end
		end
		return ans;
	endfunction

	task automatic compare_field(input string name, input logic [REQ_W-1:0] expected,
			input logic [REQ_W-1:0] actual);
		if (actual !== expected) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, name, expected, actual);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_tracked[i] = 1'b0;
				slot_free[i] = 1'b0;
				slot_bytes[i] = '0;
				slot_stamp[i] = '0;
			end
			next_stamp = '0;
			live_count = '0;
			max_buffers_reg = MAXB_RESET;
			pool_aborted = 1'b0;
			awaited_answers.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// result first: a beat taken on this edge cannot answer a command of this edge
			if (ans_mon.valid && ans_mon.ready) begin
				if (awaited_answers.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with nothing expected, status %0d", $time,
						ans_mon.status);
				end else begin
					want = awaited_answers.pop_front();
					compare_field("status", REQ_W'(want.status), REQ_W'(ans_mon.status));
					compare_field("slot", REQ_W'(want.slot), REQ_W'(ans_mon.slot));
					compare_field("slot_size", want.slot_size, ans_mon.slot_size);
					compare_field("evicted_slot", REQ_W'(want.evicted_slot),
						REQ_W'(ans_mon.evicted_slot));
				end
			end
			if (cmd_mon.valid && cmd_mon.ready)
				awaited_answers.push_back(serve_command(cmd_mon.func, cmd_mon.request_size,
					cmd_mon.release_handle, cmd_mon.handle_is_null));
			if (psel && penable && pwrite && pready && paddr == ADDR_MAX_BUFFERS)
				max_buffers_reg = pwdata[MAXB_W-1:0];
			outstanding = awaited_answers.size();
		end
	end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives commands, result back pressure and max_buffers writes into the
// best-fit buffer pool; pool_checker predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
	import bfbp_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 7;
	// cycles with no beat on any port before the run is called hung
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 160;
	// a few release-heavy rounds where equal sizes compete on free order
	localparam int RELEASE_ROUNDS = 4;
	localparam int TAIL_ITEMS   = 20;
	localparam int PHASES       = 9;
	localparam int LIMIT_PLAN [PHASES] = '{16, 1, 4, 0, 31, 7, 2, 16, 3};
	// the one func code the block has no meaning for
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 mismatches;
	int                 outstanding;
	int                 quiet_cycles = 0;
	// when clear, neither side idles or stalls
	bit                 bursty = 1'b0;
	// limit as the block applies it, used to aim releases at live slots
	int                 eff_limit = 16;

	bfbp_in_if  cmd_ch ();
	bfbp_out_if ans_ch ();

	best_fit_buffer_pool_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (cmd_ch),
		.out_ch (ans_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	pool_checker pool_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_mon    (cmd_ch),
		.ans_mon    (ans_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (!bursty)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// sizes cluster on a few values so equal sizes and close fits are common
	function automatic logic [REQ_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return REQ_W'($urandom_range(1, 6) * 64);
		if (r < 80)
			return REQ_W'($urandom_range(0, 400));
		if (r < 92)
			return REQ_W'($urandom());
		if (r < 96)
			return '0;
		return '1;
	endfunction

	// one command beat; called and returns on a falling edge, valid low again
	task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [REQ_W-1:0] size,
			input logic [HANDLE_W-1:0] handle, input logic nul);
		int gap;
		gap = pick_gap();
		repeat (gap) @(negedge clk);
		cmd_ch.valid = 1'b1;
		cmd_ch.func = func;
		cmd_ch.request_size = size;
		cmd_ch.release_handle = handle;
		cmd_ch.handle_is_null = nul;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
		cmd_ch.valid = 1'b0;
	endtask

	// unused fields carry random content
	task automatic request(input logic [REQ_W-1:0] size);
		send_cmd(FUNC_REQUEST, size, HANDLE_W'($urandom()), 1'($urandom()));
	endtask

	task automatic release_slot(input logic [HANDLE_W-1:0] handle, input logic nul);
		send_cmd(FUNC_RELEASE, REQ_W'($urandom()), handle, nul);
	endtask

	// hold the sender until every expected result beat has come back
	task automatic wait_idle();
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_max_buffers(input logic [31:0] value);
		wait_idle();
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = ADDR_MAX_BUFFERS;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		eff_limit = int'(value[MAXB_W-1:0]);
		if (eff_limit == 0)
			eff_limit = 1;
		if (eff_limit > SLOTS_DEF)
			eff_limit = SLOTS_DEF;
	endtask

	// mix of requests and releases; new slots fill from the bottom, so
	// most releases aim below the limit where slots are live
	task automatic random_item();
		int               r;
		logic [HANDLE_W-1:0] h;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 4) == 0)
			h = HANDLE_W'($urandom());
		else
			h = HANDLE_W'($urandom_range(0, eff_limit - 1));
		if (r < 50)
			request(pick_size());
		else if (r < 96)
			release_slot(h, $urandom_range(0, 11) == 0);
		else
			send_cmd(FUNC_UNUSED, REQ_W'($urandom()), HANDLE_W'($urandom()), 1'($urandom()));
	endtask

	// result side: ready drops for random stretches while bursty
	initial begin
		int stall_left;
		stall_left = 0;
		ans_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && bursty && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				ans_ch.ready = 1'b0;
				stall_left--;
			end else begin
				ans_ch.ready = 1'b1;
			end
		end
	end

	// watchdog: any beat on any port restarts the count
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (ans_ch.valid && ans_ch.ready) ||
				(psel && penable && pwrite && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		logic [31:0] cfg;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FUNC_REQUEST;
		cmd_ch.request_size = '0;
		cmd_ch.release_handle = '0;
		cmd_ch.handle_is_null = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_MAX_BUFFERS;
		pwdata = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, limit at its reset value of 16, no idling
		request('0);                  // new slot 0 of size zero
		request('1);                  // new slot 1 of the largest size
		request(REQ_W'(64));          // new slot 2
		request(REQ_W'(64));          // new slot 3, same size as slot 2
		release_slot(4'd3, 1'b0);
		release_slot(4'd2, 1'b0);
		release_slot(4'd3, 1'b0);     // already free: refreshed, now younger than 2
		request(REQ_W'(10));          // size tie, earliest freed wins: slot 2
		release_slot(4'd1, 1'b1);     // null handle ignored
		release_slot(4'd15, 1'b0);    // never tracked, ignored
		send_cmd(FUNC_UNUSED, '1, '1, 1'b1);
		release_slot(4'd1, 1'b0);
		request(REQ_W'(100));         // only the largest slot fits
		write_max_buffers(32'd1);     // four tracked, limit one: over the limit
		request(REQ_W'(200));         // nothing fits, pool full: evict slot 3
		request(REQ_W'(5));           // full and nothing free: wait
		write_max_buffers(32'd31);    // above the slot count, acts as 16
		request(REQ_W'(1));           // new slot 4

		// random phases across several limits, idling on in most of them
		for (int p = 0; p < PHASES; p++) begin
			cfg = LIMIT_PLAN[p];
			// upper bits of the write are not part of the register
			if (p == 5)
				cfg = cfg | ($urandom() << MAXB_W);
			write_max_buffers(cfg);
			bursty = (p % 3) != 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// sender holds off until the pool has answered everything
				if (n == PHASE_ITEMS / 2 || $urandom_range(0, 99) == 0)
					wait_idle();
				random_item();
			end
		end

		// release-heavy run so refreshed slots of equal size compete on free order
		write_max_buffers(32'd4);
		bursty = 1'b0;
		for (int k = 0; k < RELEASE_ROUNDS; k++) begin
			for (int j = 0; j < 16; j++)
				release_slot(HANDLE_W'($urandom_range(0, 3)), 1'b0);
			request(REQ_W'($urandom_range(1, 2) * 64));
		end

		// abort is sticky until reset, so it comes last
		bursty = 1'b1;
		send_cmd(FUNC_ABORT, REQ_W'($urandom()), HANDLE_W'($urandom()), 1'($urandom()));
		for (int n = 0; n < TAIL_ITEMS; n++) begin
			if (n == TAIL_ITEMS / 2)
				send_cmd(FUNC_ABORT, '0, '0, 1'b0);
			if (n % 2 == 0)
				request(pick_size());
			else
				random_item();
		end

		wait_idle();
		// catch any stray result beat after the last expected one
		repeat (SLOTS_DEF + 8) @(negedge clk);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* files.f */
src/bfbp_pkg.sv
src/bfbp_if.sv
src/bfbp_front.sv
src/bfbp_back.sv
src/best_fit_buffer_pool_unit.sv
sim/pool_checker.sv
sim/testbench.sv
